// ===== sv/fraction_add_integer_reduce_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the fraction add and reduce block
// Concurrent assertion wrappers shared by the controller and the datapath.
// ---------------------------------------------------------------------------
`ifndef FRACTION_ADD_INTEGER_REDUCE_TOP_ASSERT_SVH
`define FRACTION_ADD_INTEGER_REDUCE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define FAIR_ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("fair: same-cycle implication failed");

// Next-cycle implication.
`define FAIR_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("fair: next-cycle implication failed");

`else

`define FAIR_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define FAIR_ASSERT_NEXT(name, clk, rstn, ante, cons)

`endif

`endif

// ===== sv/fair_pkg.sv =====
// ---------------------------------------------------------------------------
// Fraction add and reduce package
// Shared types and codes for the controller and the datapath.
// ---------------------------------------------------------------------------
package fair_pkg;

  // Width of every numeric field on the ports.
  localparam int FIELD_W = 32;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DEN_BAD  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_SUM,
    OP_ABS,
    OP_COM,
    OP_ODD,
    OP_GCD,
    OP_DIVI,
    OP_DIV,
    OP_OUT
  } dp_op_e;

  // Datapath status seen by the controller.
  typedef struct packed {
    logic den_bad;
    logic sum_zero;
    logic both_even;
    logic a_even;
    logic b_zero;
    logic div_last;
  } fair_sta_t;

endpackage

// ===== sv/fair_dp.sv =====
// ---------------------------------------------------------------------------
// Fraction add and reduce datapath
// Product, sum, binary GCD registers, two restoring dividers and result regs.
// ---------------------------------------------------------------------------
`include "fraction_add_integer_reduce_top_assert.svh"

module fair_dp #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fair_pkg::dp_op_e                 op_i,
  output fair_pkg::fair_sta_t              sta_o,
  input  logic [fair_pkg::FIELD_W-1:0]     frac_num_i,
  input  logic [fair_pkg::FIELD_W-1:0]     frac_den_i,
  input  logic [fair_pkg::FIELD_W-1:0]     addend_i,
  output logic [fair_pkg::FIELD_W-1:0]     sum_num_o,
  output logic [fair_pkg::FIELD_W-1:0]     sum_den_o,
  output logic [1:0]                       status_o
);
  import fair_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int DW = 2 * DATA_WIDTH;
  localparam int KW = $clog2(DATA_WIDTH);
  localparam int CW = $clog2(2 * DATA_WIDTH);

  logic [W-1:0]         num_q, den_q, add_q;
  logic signed [DW-1:0] prod_q, sum_q;
  logic [DW-1:0]        mag_q, a_q, b_q;
  logic                 neg_q;
  logic [KW-1:0]        k_q;
  logic [W-1:0]         g_q;
  logic [DW-1:0]        qm_q, qd_q;
  logic [W-1:0]         rm_q, rd_q;
  logic [CW-1:0]        cnt_q;
  logic [FIELD_W-1:0]   sum_num_q, sum_den_q;
  status_e              status_q;

  logic                 den_bad, sum_zero;
  logic                 a_gt;
  logic [DW-1:0]        gcd_diff, gcd_min;
  logic [W:0]           r_m, r_d;
  logic                 ge_m, ge_d;
  logic [W-1:0]         rm_n, rd_n;
  logic [DW-1:0]        half, limit;
  logic                 ovf;
  logic [W-1:0]         num_res;

  assign den_bad  = den_q[W-1] | (den_q == '0);
  assign sum_zero = (sum_q == '0);

  // One Stein step: the smaller odd value stays, the difference goes to b.
  assign a_gt     = a_q > b_q;
  assign gcd_diff = a_gt ? (a_q - b_q) : (b_q - a_q);
  assign gcd_min  = a_gt ? b_q : a_q;

  // Restoring division, one quotient bit per cycle for each dividend.
  assign r_m  = {rm_q, qm_q[DW-1]};
  assign r_d  = {rd_q, qd_q[DW-1]};
  assign ge_m = r_m >= {1'b0, g_q};
  assign ge_d = r_d >= {1'b0, g_q};
  assign rm_n = ge_m ? W'(r_m - {1'b0, g_q}) : r_m[W-1:0];
  assign rd_n = ge_d ? W'(r_d - {1'b0, g_q}) : r_d[W-1:0];

  // The reduced magnitude must fit the signed range of the data width.
  assign half    = DW'(1) << (W - 1);
  assign limit   = neg_q ? half : (half - DW'(1));
  assign ovf     = qm_q > limit;
  assign num_res = neg_q ? (W'(0) - qm_q[W-1:0]) : qm_q[W-1:0];

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        num_q <= frac_num_i[W-1:0];
        den_q <= frac_den_i[W-1:0];
        add_q <= addend_i[W-1:0];
      end
      OP_MUL: begin
        prod_q <= $signed(add_q) * $signed(den_q);
      end
      OP_SUM: begin
        sum_q <= prod_q + DW'($signed(num_q));
      end
      OP_ABS: begin
        a_q   <= sum_q[DW-1] ? (DW'(0) - sum_q) : sum_q;
        mag_q <= sum_q[DW-1] ? (DW'(0) - sum_q) : sum_q;
        neg_q <= sum_q[DW-1];
        b_q   <= DW'(den_q);
        k_q   <= '0;
      end
      OP_COM: begin
        a_q <= a_q >> 1;
        b_q <= b_q >> 1;
        k_q <= k_q + KW'(1);
      end
      OP_ODD: begin
        a_q <= a_q >> 1;
      end
      OP_GCD: begin
        if (!b_q[0]) begin
          b_q <= b_q >> 1;
        end else begin
          a_q <= gcd_min;
          b_q <= gcd_diff;
        end
      end
      OP_DIVI: begin
        g_q   <= W'(a_q[W-1:0] << k_q);
        qm_q  <= mag_q;
        qd_q  <= DW'(den_q);
        rm_q  <= '0;
        rd_q  <= '0;
        cnt_q <= '0;
      end
      OP_DIV: begin
        qm_q  <= {qm_q[DW-2:0], ge_m};
        qd_q  <= {qd_q[DW-2:0], ge_d};
        rm_q  <= rm_n;
        rd_q  <= rd_n;
        cnt_q <= cnt_q + CW'(1);
      end
      OP_OUT: begin
        if (den_bad) begin
          sum_num_q <= FIELD_W'($signed(num_q));
          sum_den_q <= FIELD_W'($signed(den_q));
          status_q  <= ST_DEN_BAD;
        end else if (sum_zero) begin
          sum_num_q <= '0;
          sum_den_q <= FIELD_W'(1);
          status_q  <= ST_OK;
        end else if (ovf) begin
          sum_num_q <= FIELD_W'($signed(num_q));
          sum_den_q <= FIELD_W'($signed(qd_q[W-1:0]));
          status_q  <= ST_OVERFLOW;
        end else begin
          sum_num_q <= FIELD_W'($signed(num_res));
          sum_den_q <= FIELD_W'($signed(qd_q[W-1:0]));
          status_q  <= ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sta_o.den_bad   = den_bad;
    sta_o.sum_zero  = sum_zero;
    sta_o.both_even = ~a_q[0] & ~b_q[0];
    sta_o.a_even    = ~a_q[0];
    sta_o.b_zero    = (b_q == '0);
    sta_o.div_last  = (cnt_q == CW'(DW - 1));
  end

  assign sum_num_o = sum_num_q;
  assign sum_den_o = sum_den_q;
  assign status_o  = status_q;

  // The odd part of the GCD is never zero when division starts.
  `FAIR_ASSERT_IMPL(a_gcd_nonzero, clk_i, rst_ni, op_i == OP_DIVI, a_q != '0)
  // The GCD divides both values exactly, so both remainders end at zero.
  `FAIR_ASSERT_IMPL(a_exact_div, clk_i, rst_ni, (op_i == OP_OUT) && !den_bad && !sum_zero, (rm_q == '0) && (rd_q == '0))

endmodule

// ===== sv/fair_ctrl.sv =====
// ---------------------------------------------------------------------------
// Fraction add and reduce controller
// Sequences load, multiply, sum, GCD, division and result hand-off.
// ---------------------------------------------------------------------------
`include "fraction_add_integer_reduce_top_assert.svh"

module fair_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  fair_pkg::fair_sta_t sta_i,
  output fair_pkg::dp_op_e    op_o
);
  import fair_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_ABS,
    S_COM,
    S_ODD,
    S_LOOP,
    S_DIVI,
    S_DIV,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = ~out_valid_q | out_ready_i;

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = OP_LOAD;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        op_o    = OP_MUL;
        state_d = S_SUM;
      end
      S_SUM: begin
        op_o    = OP_SUM;
        state_d = S_ABS;
      end
      S_ABS: begin
        op_o    = OP_ABS;
        state_d = (sta_i.den_bad | sta_i.sum_zero) ? S_FIN : S_COM;
      end
      S_COM: begin
        if (sta_i.both_even) begin
          op_o = OP_COM;
        end else begin
          state_d = S_ODD;
        end
      end
      S_ODD: begin
        if (sta_i.a_even) begin
          op_o = OP_ODD;
        end else begin
          state_d = S_LOOP;
        end
      end
      S_LOOP: begin
        if (sta_i.b_zero) begin
          state_d = S_DIVI;
        end else begin
          op_o = OP_GCD;
        end
      end
      S_DIVI: begin
        op_o    = OP_DIVI;
        state_d = S_DIV;
      end
      S_DIV: begin
        op_o = OP_DIV;
        if (sta_i.div_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          op_o    = OP_OUT;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (op_o == OP_OUT) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // A result is only written into a free or emptying output register.
  `FAIR_ASSERT_IMPL(a_out_no_overwrite, clk_i, rst_ni, op_o == OP_OUT, out_free)
  // An accepted request always starts with the multiply.
  `FAIR_ASSERT_NEXT(a_accept_to_mul, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == S_MUL)
  // The last division step hands over to the result stage.
  `FAIR_ASSERT_NEXT(a_div_to_fin, clk_i, rst_ni, (state_q == S_DIV) && sta_i.div_last, state_q == S_FIN)

endmodule

// ===== sv/fraction_add_integer_reduce_top.sv =====
// ---------------------------------------------------------------------------
// Fraction add and reduce, top level
// Computes (frac_num + addend * frac_den) / frac_den in lowest terms.
// ---------------------------------------------------------------------------
//
//   Channel | Handshake              | Payload
//   --------+------------------------+-------------------------------------
//   in      | in_valid_i / in_ready_o | frac_num_i, frac_den_i, addend_i
//   out     | out_valid_o/out_ready_i | sum_num_o, sum_den_o, status_o
//
// One request is processed at a time. A request whose denominator is not
// positive, or whose sum is zero, is loaded, multiplied, summed and passed
// through the magnitude step straight to the result stage. Otherwise the
// block then strips the shared and the remaining trailing zeros one bit per
// cycle, runs the binary GCD loop (one subtract or one shift per step), and
// divides in the two restoring dividers, which run side by side one bit a
// cycle, before the result stage.
// The reset is asynchronous and active low; it clears only control state.
// While a result waits on a stalled output, the next request is still taken
// and computed; it waits in the controller until the output register frees.
//
// The numerator sum is formed at full double width, so it never overflows.
// Both reduced values come from exact division by the GCD, and the reduced
// numerator is range-checked against the signed range of DATA_WIDTH, giving
// the overflow status when it does not fit.

module fraction_add_integer_reduce_top #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [fair_pkg::FIELD_W-1:0] frac_num_i,
  input  logic [fair_pkg::FIELD_W-1:0] frac_den_i,
  input  logic [fair_pkg::FIELD_W-1:0] addend_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [fair_pkg::FIELD_W-1:0] sum_num_o,
  output logic [fair_pkg::FIELD_W-1:0] sum_den_o,
  output logic [1:0]                   status_o
);
  import fair_pkg::*;

  // Operation for the datapath this cycle, and the flags it reports back.
  dp_op_e    op;
  fair_sta_t sta;

  // The controller owns the handshakes and the output valid flag.
  fair_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sta_i       (sta),
    .op_o        (op)
  );

  // The datapath holds every operand, the GCD state and the result registers.
  fair_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .sta_o      (sta),
    .frac_num_i (frac_num_i),
    .frac_den_i (frac_den_i),
    .addend_i   (addend_i),
    .sum_num_o  (sum_num_o),
    .sum_den_o  (sum_den_o),
    .status_o   (status_o)
  );

endmodule

// ===== verif/tb_fraction_add_integer_reduce_top.sv =====
// ---------------------------------------------------------------------------
// Testbench for the fraction add and reduce block
// Sends fractions plus integers through the valid/ready input channel and
// checks every reduced sum, field by field, against a local predictor.
// ---------------------------------------------------------------------------
module tb_fraction_add_integer_reduce_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fair_pkg::*;

  // Data width of the instance and the range limits of a field at that width.
  localparam int DW = 32;
  localparam logic [FIELD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [FIELD_W-1:0] WORD_MIN = 32'h8000_0000;

  // Percentage of cycles in which either side holds off at random.
  localparam int IDLE_PCT = 17;
  // Comfortably longer than a request can still be busy in the worst case.
  localparam int SETTLE_CYCLES = 400;
  // About five times the slowest correct run of all requests.
  localparam int unsigned CYCLE_LIMIT = 2_500_000;

  // One reduced sum as it appears on the output ports.
  typedef struct packed {
    logic [FIELD_W-1:0] num;
    logic [FIELD_W-1:0] den;
    status_e            status;
  } fraction_sum_t;

  logic               clk_i = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [FIELD_W-1:0] frac_num = '0;
  logic [FIELD_W-1:0] frac_den = '0;
  logic [FIELD_W-1:0] addend = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [FIELD_W-1:0] sum_num;
  logic [FIELD_W-1:0] sum_den;
  logic [1:0]         status;

  // Reduced sums still owed by the block, oldest first.
  fraction_sum_t pending_sums[$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;
  // While set, neither side idles: used for the back-to-back stretch.
  logic          steady_flow = 1'b0;

  fraction_add_integer_reduce_top #(
    .DATA_WIDTH(DW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .frac_num_i (frac_num),
    .frac_den_i (frac_den),
    .addend_i   (addend),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .sum_num_o  (sum_num),
    .sum_den_o  (sum_den),
    .status_o   (status)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Interpret the low DW bits of a port value as a signed number.
  function automatic longint signed_at_width(logic [FIELD_W-1:0] raw);
    longint unsigned v;
    v = longint'(raw) & ((64'd1 << DW) - 64'd1);
    if (v[DW-1]) begin
      return longint'(v) - (longint'(1) << DW);
    end
    return longint'(v);
  endfunction

  // Expected result of one request. The unreduced numerator is formed in
  // 64 bits, where it cannot overflow, and reduced by Euclid's GCD.
  function automatic fraction_sum_t reduce_fraction_sum(logic [FIELD_W-1:0] num_raw,
                                                        logic [FIELD_W-1:0] den_raw,
                                                        logic [FIELD_W-1:0] add_raw);
    longint          num;
    longint          den;
    longint          add;
    longint          total;
    longint unsigned mag;
    longint unsigned a;
    longint unsigned b;
    longint unsigned rest;
    longint unsigned red_mag;
    longint unsigned red_den;
    longint unsigned bound;
    longint          signed_mag;
    logic            neg;
    fraction_sum_t   res;
    num = signed_at_width(num_raw);
    den = signed_at_width(den_raw);
    add = signed_at_width(add_raw);
    // A denominator that is not positive passes the fraction straight through.
    if (den <= 0) begin
      res.num    = num[FIELD_W-1:0];
      res.den    = den[FIELD_W-1:0];
      res.status = ST_DEN_BAD;
      return res;
    end
    total = num + add * den;
    if (total == 0) begin
      res.num    = '0;
      res.den    = 1;
      res.status = ST_OK;
      return res;
    end
    neg = (total < 0);
    mag = neg ? longint'(-total) : total;
    a = mag;
    b = den;
    while (b != 0) begin
      rest = a % b;
      a = b;
      b = rest;
    end
    red_mag = mag / a;
    red_den = longint'(den) / a;
    // Negative results may reach one step further than positive ones.
    bound = neg ? (64'd1 << (DW - 1)) : ((64'd1 << (DW - 1)) - 64'd1);
    res.den = red_den[FIELD_W-1:0];
    if (red_mag > bound) begin
      res.num    = num[FIELD_W-1:0];
      res.status = ST_OVERFLOW;
    end else begin
      signed_mag = neg ? -longint'(red_mag) : longint'(red_mag);
      res.num    = signed_mag[FIELD_W-1:0];
      res.status = ST_OK;
    end
    return res;
  endfunction

  // Present one request, hold it until the block takes it, and record the
  // sum it must produce. Valid is only lowered when a gap is inserted, so a
  // back-to-back request never sees valid dropped and raised in one step.
  task automatic send_request(input logic [FIELD_W-1:0] num,
                              input logic [FIELD_W-1:0] den,
                              input logic [FIELD_W-1:0] add);
    int gap;
    gap = 0;
    if (!steady_flow) begin
      while ($urandom_range(99) < IDLE_PCT) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    frac_num <= num;
    frac_den <= den;
    addend   <= add;
    do @(posedge clk_i); while (!in_ready);
    pending_sums.push_back(reduce_fraction_sum(num, den, add));
  endtask

  // A random request drawn from a mix that favors well-formed fractions with
  // shared factors, so that the GCD and both divisions do real work. The
  // rest covers raw noise, bad denominators, sums that cancel to zero, and
  // sums too large to reduce into range.
  function automatic void pick_random_request(output logic [FIELD_W-1:0] num,
                                              output logic [FIELD_W-1:0] den,
                                              output logic [FIELD_W-1:0] add);
    int          d;
    int          a;
    int unsigned factor;
    num = $urandom;
    den = $urandom;
    add = $urandom;
    case ($urandom_range(19))
      0, 1: begin
        // Raw noise over every bit of every field.
      end
      2: begin
        den = ($urandom_range(3) == 0) ? '0 : ($urandom | WORD_MIN);
      end
      3, 4: begin
        d   = $urandom_range(46340, 1);
        a   = int'($urandom_range(92680)) - 46340;
        num = -(a * d);
        den = d;
        add = a;
      end
      5, 6: begin
        den = $urandom_range(8, 1);
      end
      7, 8: begin
        den = $urandom & WORD_MAX;
        if (den == 0) den = 1;
        add = int'($urandom_range(64)) - 32;
      end
      default: begin
        // Shared factor with an odd part and some trailing zeros.
        factor = (2 * $urandom_range(2047) + 1) << $urandom_range(12);
        den    = factor * $urandom_range(64, 1);
        num    = int'(factor) * (int'($urandom_range(200)) - 100);
        add    = ($urandom_range(4) == 0) ? $urandom : (int'($urandom_range(64)) - 32);
      end
    endcase
  endfunction

  // Corner values: field extremes, every status, cancellation to zero,
  // negative sums, shared powers of two and the signed range boundary.
  task automatic test_directed_cases();
    send_request(1, 1, 0);
    send_request(6, 4, 1);
    send_request(-32'sd6, 3, 2);
    send_request(-32'sd7, 3, 1);
    send_request(5, 0, 3);
    send_request(5, -32'sd1, 3);
    send_request(WORD_MIN, WORD_MIN, WORD_MAX);
    send_request(WORD_MAX, 1, 1);
    send_request(WORD_MIN, 1, 0);
    send_request(WORD_MIN, 1, -32'sd1);
    send_request(WORD_MAX, WORD_MAX, WORD_MAX);
    send_request(WORD_MIN, WORD_MAX, WORD_MIN);
    send_request(0, WORD_MAX, 0);
    send_request(32'h4000_0000, 32'h4000_0000, 0);
    send_request(12, 32'h0010_0000, 3);
    send_request(0, 7, 5);
    send_request(-32'sd1, 2, WORD_MIN);
    send_request(WORD_MAX, 2, -32'sd1);
    send_request(9, 15, -32'sd1);
    send_request(32'hFFFF_FFFF, WORD_MAX, 1);
    send_request(WORD_MIN, 2, WORD_MAX);
  endtask

  // The bulk of the run: random requests with random idling on both sides.
  task automatic test_random_mix(input int count);
    logic [FIELD_W-1:0] num;
    logic [FIELD_W-1:0] den;
    logic [FIELD_W-1:0] add;
    repeat (count) begin
      pick_random_request(num, den, add);
      send_request(num, den, add);
    end
  endtask

  // A long stretch where neither side ever holds off, so the block sees a
  // new request while its previous result is still being handed over.
  task automatic test_back_to_back(input int count);
    steady_flow = 1'b1;
    test_random_mix(count);
    steady_flow = 1'b0;
  endtask

  // The sender stops until every result is back, then resumes with random
  // requests, so the block starts again from a fully idle state.
  task automatic test_drain_and_resume(input int count);
    in_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk_i);
    test_random_mix(count);
  endtask

  // The receiver holds off at random, except during the steady stretch.
  always @(posedge clk_i) begin
    out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
  end

  // Each result taken from the block is matched against the oldest owed sum.
  always @(posedge clk_i) begin : check_results
    fraction_sum_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_sums.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result num=%h den=%h status=%0d", sum_num, sum_den, status);
        end
      end else begin
        want = pending_sums.pop_front();
        if (sum_num !== want.num || sum_den !== want.den || status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected num=%h den=%h status=%0d, got num=%h den=%h status=%0d",
                     want.num, want.den, want.status, sum_num, sum_den, status);
          end
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_mix(600);
    test_back_to_back(200);
    test_drain_and_resume(700);

    // Let every owed result come back, then give the block time to show
    // any result that it should not produce.
    in_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_sums.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
